// ===== hdl/string_escape_decoder_top_macros.svh =====
// assertion macros used by the escape decoder checker
`ifndef STRING_ESCAPE_DECODER_TOP_MACROS_SVH
`define STRING_ESCAPE_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define SED_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sed check failed");

// next-cycle implication, disabled while reset is active
`define SED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sed check failed");

`endif

// ===== hdl/sed_pkg.sv =====
// shared types and constants of the string escape decoder
package sed_pkg;

  localparam int unsigned MAX_RESULTS    = 4;
  localparam int unsigned CNT_W          = $clog2(MAX_RESULTS + 1);
  localparam int unsigned IDX_W          = $clog2(MAX_RESULTS);
  localparam int unsigned FIFO_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRAIL    = 3'd1,
    ST_X_HEX    = 3'd2,
    ST_U4_HEX   = 3'd3,
    ST_U8_HEX   = 3'd4,
    ST_SURR     = 3'd5,
    ST_OVERFLOW = 3'd6,
    ST_UNKNOWN  = 3'd7
  } status_e;

  // parser modes of the front end
  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_XFIRST  = 3'd2,
    MODE_XSECOND = 3'd3,
    MODE_U4      = 3'd4,
    MODE_U8      = 3'd5,
    MODE_DROP    = 3'd6
  } mode_e;

  // results caused by one input byte: decoded bytes first, then an optional error
  typedef struct packed {
    logic [CNT_W-1:0]             cnt;
    logic [MAX_RESULTS-1:0][7:0]  data;
    status_e                      err;
    logic                         last;
  } run_t;

endpackage

// ===== hdl/sed_front.sv =====
// front end: escape parser state machine, builds one result run per input byte
module sed_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  logic          full_i,
  output logic          push_o,
  output sed_pkg::run_t run_o
);
  import sed_pkg::*;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] value;
  } esc_t;

  typedef struct packed {
    logic [CNT_W-1:0]            cnt;
    logic [MAX_RESULTS-1:0][7:0] data;
  } utf8_t;

  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_X      = 8'h78;
  localparam logic [7:0]  CH_U_LO   = 8'h75;
  localparam logic [7:0]  CH_U_UP   = 8'h55;
  localparam logic [3:0]  DIGITS_U4 = 4'd4;
  localparam logic [3:0]  DIGITS_U8 = 4'd8;
  localparam logic [31:0] CP_MAX    = 32'h0010_FFFF;
  localparam logic [31:0] SURR_LO   = 32'h0000_D800;
  localparam logic [31:0] SURR_HI   = 32'h0000_DFFF;
  localparam logic [31:0] CP_1B     = 32'h0000_007F;
  localparam logic [31:0] CP_2B     = 32'h0000_07FF;
  localparam logic [31:0] CP_3B     = 32'h0000_FFFF;

  function automatic hex_t hex_of(input logic [7:0] c);
    hex_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok = 1'b1; r.nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.ok = 1'b1; r.nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok = 1'b1; r.nib = 4'(c - 8'h37);
    end
    return r;
  endfunction

  function automatic esc_t single_escape(input logic [7:0] c);
    esc_t r;
    r.ok = 1'b1;
    unique case (c)
      8'h61:   r.value = 8'h07; // a
      8'h62:   r.value = 8'h08; // b
      8'h65:   r.value = 8'h1B; // e
      8'h66:   r.value = 8'h0C; // f
      8'h6E:   r.value = 8'h0A; // n
      8'h72:   r.value = 8'h0D; // r
      8'h74:   r.value = 8'h09; // t
      8'h76:   r.value = 8'h0B; // v
      8'h5C:   r.value = 8'h5C; // backslash
      8'h27:   r.value = 8'h27; // single quote
      8'h22:   r.value = 8'h22; // double quote
      8'h30:   r.value = 8'h00; // zero
      8'h3F:   r.value = 8'h3F; // question mark
      default: begin
        r.ok = 1'b0; r.value = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [31:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= CP_1B) begin
      r.cnt = CNT_W'(1);
      r.data[0] = cp[7:0];
    end else if (cp <= CP_2B) begin
      r.cnt = CNT_W'(2);
      r.data[0] = {3'b110, cp[10:6]};
      r.data[1] = {2'b10, cp[5:0]};
    end else if (cp <= CP_3B) begin
      r.cnt = CNT_W'(3);
      r.data[0] = {4'b1110, cp[15:12]};
      r.data[1] = {2'b10, cp[11:6]};
      r.data[2] = {2'b10, cp[5:0]};
    end else begin
      r.cnt = CNT_W'(4);
      r.data[0] = {5'b11110, cp[20:18]};
      r.data[1] = {2'b10, cp[17:12]};
      r.data[2] = {2'b10, cp[11:6]};
      r.data[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  mode_e       mode_q, mode_d, mode_mid;
  logic [31:0] acc_q, acc_d, acc_mid, acc_sh;
  logic [3:0]  dig_q, dig_d, dig_mid, dig_inc;
  status_e     err_main, err_fin;
  hex_t        h;
  esc_t        esc;
  utf8_t       enc;
  logic        complete, cp_over, cp_surr, accept;
  logic [CNT_W-1:0]            nb;
  logic [MAX_RESULTS-1:0][7:0] data;

  assign accept   = valid_i && !full_i;
  assign h        = hex_of(byte_i);
  assign esc      = single_escape(byte_i);
  assign acc_sh   = {acc_q[27:0], h.nib};
  assign dig_inc  = dig_q + 4'd1;
  assign complete = h.ok && (dig_inc == ((mode_q == MODE_U4) ? DIGITS_U4 : DIGITS_U8));
  assign cp_over  = (mode_q == MODE_U8) && (acc_sh > CP_MAX);
  assign cp_surr  = (acc_sh >= SURR_LO) && (acc_sh <= SURR_HI);
  assign enc      = utf8_encode(acc_sh);

  always_comb begin : next_state
    mode_mid = mode_q;
    acc_mid  = acc_q;
    dig_mid  = dig_q;
    err_main = ST_OK;
    unique case (mode_q) inside
      MODE_ESC: begin
        if (esc.ok) begin
          mode_mid = MODE_NORMAL;
        end else if (byte_i == CH_X) begin
          mode_mid = MODE_XFIRST;
        end else if (byte_i == CH_U_LO || byte_i == CH_U_UP) begin
          mode_mid = (byte_i == CH_U_LO) ? MODE_U4 : MODE_U8;
          acc_mid  = '0;
          dig_mid  = '0;
        end else begin
          err_main = ST_UNKNOWN;
        end
      end
      MODE_XFIRST: begin
        if (!h.ok) begin
          err_main = ST_X_HEX;
        end else begin
          acc_mid  = {28'd0, h.nib};
          mode_mid = MODE_XSECOND;
        end
      end
      MODE_XSECOND: begin
        mode_mid = (!h.ok && byte_i == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
      end
      MODE_U4, MODE_U8: begin
        if (!h.ok) begin
          err_main = (mode_q == MODE_U4) ? ST_U4_HEX : ST_U8_HEX;
        end else begin
          acc_mid = acc_sh;
          dig_mid = dig_inc;
          if (complete) begin
            if (cp_over)      err_main = ST_OVERFLOW;
            else if (cp_surr) err_main = ST_SURR;
            else              mode_mid = MODE_NORMAL;
          end
        end
      end
      MODE_DROP: begin
      end
      default: begin
        mode_mid = (byte_i == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
      end
    endcase

    // an escape still open on the final byte is an error
    err_fin = err_main;
    if (err_main == ST_OK && last_i) begin
      case (mode_mid)
        MODE_ESC:    err_fin = ST_TRAIL;
        MODE_XFIRST: err_fin = ST_X_HEX;
        MODE_U4:     err_fin = ST_U4_HEX;
        MODE_U8:     err_fin = ST_U8_HEX;
        default:     err_fin = ST_OK;
      endcase
    end

    if (last_i) begin
      mode_d = MODE_NORMAL;
      acc_d  = '0;
      dig_d  = '0;
    end else if (err_fin != ST_OK) begin
      mode_d = MODE_DROP;
      acc_d  = acc_mid;
      dig_d  = dig_mid;
    end else begin
      mode_d = mode_mid;
      acc_d  = acc_mid;
      dig_d  = dig_mid;
    end
  end

  always_comb begin : outputs
    nb   = '0;
    data = '0;
    unique case (mode_q) inside
      MODE_ESC: begin
        if (esc.ok) begin
          nb = CNT_W'(1); data[0] = esc.value;
        end
      end
      MODE_XFIRST: begin
        // lone digit flushed at the end of the literal
        if (last_i && h.ok) begin
          nb = CNT_W'(1); data[0] = {4'd0, h.nib};
        end
      end
      MODE_XSECOND: begin
        if (h.ok) begin
          nb = CNT_W'(1); data[0] = {acc_q[3:0], h.nib};
        end else begin
          data[0] = acc_q[7:0];
          if (byte_i != CH_BSLASH) begin
            nb = CNT_W'(2); data[1] = byte_i;
          end else begin
            nb = CNT_W'(1);
          end
        end
      end
      MODE_U4, MODE_U8: begin
        if (complete && err_main == ST_OK) begin
          nb   = enc.cnt;
          data = enc.data;
        end
      end
      MODE_DROP: begin
      end
      default: begin
        if (byte_i != CH_BSLASH) begin
          nb = CNT_W'(1); data[0] = byte_i;
        end
      end
    endcase
    run_o.cnt  = nb + CNT_W'(err_fin != ST_OK);
    run_o.data = data;
    run_o.err  = err_fin;
    run_o.last = last_i;
  end

  assign push_o = accept && (run_o.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      acc_q  <= '0;
      dig_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      dig_q  <= dig_d;
    end
  end

endmodule

// ===== hdl/sed_fifo.sv =====
// small queue of result runs between front and back end
module sed_fifo #(
  parameter int unsigned DEPTH = sed_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sed_pkg::run_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sed_pkg::run_t data_o
);
  import sed_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  run_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      if (do_push && !do_pop)      count_q <= count_q + CW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CW'(1);
    end
  end

endmodule

// ===== hdl/sed_back.sv =====
// back end: serializes each run into single results through an output register
module sed_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  sed_pkg::run_t run_i,
  output logic          pop_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output logic [7:0]    m_tdata_o,
  output logic          m_tlast_o,
  output logic [4:0]    m_tuser_o
);
  import sed_pkg::*;

  logic [IDX_W-1:0] idx_q;
  logic             valid_q;
  logic [7:0]       data_q;
  logic             tlast_q;
  logic [4:0]       tuser_q;
  logic             load, entry_last, is_err;
  status_e          status;

  assign load       = !empty_i && (!valid_q || m_tready_i);
  assign entry_last = ({1'b0, idx_q} == (run_i.cnt - CNT_W'(1)));
  assign is_err     = entry_last && (run_i.err != ST_OK);
  assign status     = is_err ? run_i.err : ST_OK;
  assign pop_o      = load && entry_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= entry_last ? '0 : idx_q + IDX_W'(1);
        valid_q <= 1'b1;
      end else if (m_tready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q  <= is_err ? 8'h00 : run_i.data[idx_q];
      tlast_q <= entry_last && (is_err || run_i.last);
      tuser_q <= {entry_last, status, !is_err};
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = data_q;
  assign m_tlast_o  = tlast_q;
  assign m_tuser_o  = tuser_q;

endmodule

// ===== hdl/string_escape_decoder_top.sv =====
// top level of the string escape decoder
// usage:
//   slave stream: one raw byte of a string literal per transfer, tlast on the
//   final byte of the literal. master stream: one decoded result per transfer.
//   plain bytes and single-character escapes give one result, \x one or two
//   hex digits one byte, \u and \U code points one to four utf-8 bytes.
//   an error gives one result with status set and tlast high; the rest of the
//   literal is then swallowed. a byte may give no result at all.
// path: the run of each byte is written into the run queue, and its results are
//   then loaded from the queue into the output register one by one.
// throughput: one byte per cycle in, one result per cycle out while
//   m_axis_tready_i is high; a byte that expands to k results holds the output for
//   k transfers, and the run queue between parser and serializer absorbs that until
//   it fills, after which s_axis_tready_o drops.
// reset: parser returns to plain text, queue and output register empty.
// stall: with m_axis_tready_i low the output holds; the parser keeps taking
//   bytes until the queue is full.
module string_escape_decoder_top #(
  parameter int unsigned FIFO_DEPTH = sed_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // literal_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // literal_end
  output logic [4:0] m_axis_tuser_o    // [0] byte_valid, [3:1] status, [4] run_last
);
  import sed_pkg::*;

  run_t run_in, run_out;
  logic push, full, pop, empty;

  // parser takes a byte whenever the run queue has room
  assign s_axis_tready_o = !full;

  sed_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .byte_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .full_i  (full),
    .push_o  (push),
    .run_o   (run_in)
  );

  // runs waiting to be serialized
  sed_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (run_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (run_out)
  );

  // one result per transfer, output register parts the two sides
  sed_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .run_i      (run_out),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== hdl/sed_checker.sv =====
// port-level checks of the string escape decoder, bound to the top level
`include "string_escape_decoder_top_macros.svh"

module sed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic [4:0] m_axis_tuser_o
);
  import sed_pkg::*;

  // a stalled result holds its payload
  `SED_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
    && $stable(m_axis_tlast_o))

  // error result: no byte, ends the literal and the run
  `SED_ASSERT_NOW(a_err_shape, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o[3:1] != ST_OK),
    (m_axis_tdata_o == 8'h00) && !m_axis_tuser_o[0] && m_axis_tlast_o && m_axis_tuser_o[4])

  // a decoded byte always carries ok status
  `SED_ASSERT_NOW(a_byte_ok, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0],
    m_axis_tuser_o[3:1] == ST_OK)

  // end of literal is always the last result of its byte
  `SED_ASSERT_NOW(a_end_run, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o,
    m_axis_tuser_o[4])

endmodule

bind string_escape_decoder_top sed_checker u_sed_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
